>>> rtl/assert_macros.svh
// assertion helpers for the rtl files (included by the controller)
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> rtl/dpc_pkg.sv
package dpc_pkg;

   // fixed field widths
   localparam int DEPTH_W     = 16;
   localparam int COORD_W     = 33;
   localparam int Z_W         = 17;
   localparam int DIM_REG_W   = 13;
   localparam int RECIP_W     = 25;
   localparam int CSR_DATA_W  = 25;
   localparam int CSR_INDEX_W = 3;

   // fixed point scaling: centre halving, q24 reciprocal, 1/16 units
   localparam int COORD_SHIFT = 21;

   localparam logic [DEPTH_W-1:0] INVALID_DEPTH = 16'hFFFF;

   // register reset values
   localparam logic [DIM_REG_W-1:0] RESET_IMAGE_WIDTH  = 13'd640;
   localparam logic [DIM_REG_W-1:0] RESET_IMAGE_HEIGHT = 13'd480;
   localparam logic [RECIP_W-1:0]   RESET_RECIP_FOCAL  = 25'd20972;
   localparam logic [DEPTH_W-1:0]   RESET_MIN_DEPTH    = 16'hFFFF;
   localparam logic [DEPTH_W-1:0]   RESET_MAX_DEPTH    = 16'h0000;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_IMAGE_WIDTH       = 3'd0,
      CSR_IMAGE_HEIGHT      = 3'd1,
      CSR_RECIP_FOCAL_X     = 3'd2,
      CSR_RECIP_FOCAL_Y     = 3'd3,
      CSR_INITIAL_MIN_DEPTH = 3'd4,
      CSR_INITIAL_MAX_DEPTH = 3'd5
   } csr_index_type;

   // controller states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL1,
      ST_MUL2,
      ST_FINISH
   } state_type;

   // controller to datapath commands
   typedef struct packed {
      logic take;
      logic mul1;
      logic mul2;
      logic load;
   } dp_cmd_type;

   // tracker preload from a register write
   typedef struct packed {
      logic               load_min;
      logic               load_max;
      logic [DEPTH_W-1:0] value;
   } tracker_load_type;

endpackage

>>> rtl/dpc_csr.sv
module dpc_csr
   import dpc_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = 4096
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]    csr_write_data,
   output logic [$clog2(MAX_IMAGE_DIM):0] image_width,
   output logic [$clog2(MAX_IMAGE_DIM):0] image_height,
   output logic [RECIP_W-1:0]       recip_focal_x,
   output logic [RECIP_W-1:0]       recip_focal_y,
   output tracker_load_type         tracker_load
);

   localparam int DIM_W = $clog2(MAX_IMAGE_DIM) + 1;
   localparam int CMP_W = (DIM_W > DIM_REG_W) ? DIM_W : DIM_REG_W;
   localparam logic [CMP_W-1:0] MAX_DIM = CMP_W'(MAX_IMAGE_DIM);

   // zero acts as one, oversize acts as the maximum
   function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_REG_W-1:0] v);
      logic [CMP_W-1:0] vx;
      vx = CMP_W'(v);
      if (vx == '0) begin
         clamp_dim = DIM_W'(1);
      end else if (vx > MAX_DIM) begin
         clamp_dim = DIM_W'(MAX_IMAGE_DIM);
      end else begin
         clamp_dim = DIM_W'(vx);
      end
   endfunction

   logic [DIM_W-1:0]   width_ff, width_in;
   logic [DIM_W-1:0]   height_ff, height_in;
   logic [RECIP_W-1:0] recip_x_ff, recip_x_in;
   logic [RECIP_W-1:0] recip_y_ff, recip_y_in;

   // register write decode, sizes stored already clamped
   always_comb begin
      width_in              = width_ff;
      height_in             = height_ff;
      recip_x_in            = recip_x_ff;
      recip_y_in            = recip_y_ff;
      tracker_load.load_min = 1'b0;
      tracker_load.load_max = 1'b0;
      tracker_load.value    = csr_write_data[DEPTH_W-1:0];
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_IMAGE_WIDTH:       width_in   = clamp_dim(csr_write_data[DIM_REG_W-1:0]);
            CSR_IMAGE_HEIGHT:      height_in  = clamp_dim(csr_write_data[DIM_REG_W-1:0]);
            CSR_RECIP_FOCAL_X:     recip_x_in = csr_write_data[RECIP_W-1:0];
            CSR_RECIP_FOCAL_Y:     recip_y_in = csr_write_data[RECIP_W-1:0];
            CSR_INITIAL_MIN_DEPTH: tracker_load.load_min = 1'b1;
            CSR_INITIAL_MAX_DEPTH: tracker_load.load_max = 1'b1;
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= clamp_dim(RESET_IMAGE_WIDTH);
         height_ff  <= clamp_dim(RESET_IMAGE_HEIGHT);
         recip_x_ff <= RESET_RECIP_FOCAL;
         recip_y_ff <= RESET_RECIP_FOCAL;
      end else begin
         width_ff   <= width_in;
         height_ff  <= height_in;
         recip_x_ff <= recip_x_in;
         recip_y_ff <= recip_y_in;
      end
   end

   assign image_width   = width_ff;
   assign image_height  = height_ff;
   assign recip_focal_x = recip_x_ff;
   assign recip_focal_y = recip_y_ff;

endmodule

>>> rtl/dpc_ctrl.sv
`include "assert_macros.svh"

module dpc_ctrl
   import dpc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output dp_cmd_type cmd
);

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // state register and output slot flag
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_stall = 1'b1;
      unique case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            // load only once the output slot is free or leaving
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output slot fills on load, empties when taken
   always_comb begin
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   `ASSERT_NEXT(a_take_starts_mul, clock, reset, req_valid && !req_stall, state_ff == ST_MUL1)
   `ASSERT_NEXT(a_mul1_then_mul2, clock, reset, state_ff == ST_MUL1, state_ff == ST_MUL2)
   `ASSERT_IMPLIES(a_load_slot_free, clock, reset, cmd.load, !rsp_valid_ff || !rsp_stall)

endmodule

>>> rtl/dpc_datapath.sv
module dpc_datapath
   import dpc_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = 4096
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dp_cmd_type                    cmd,
   input  logic [DEPTH_W-1:0]            req_depth_sample,
   input  logic [$clog2(MAX_IMAGE_DIM):0] image_width,
   input  logic [$clog2(MAX_IMAGE_DIM):0] image_height,
   input  logic [RECIP_W-1:0]            recip_focal_x,
   input  logic [RECIP_W-1:0]            recip_focal_y,
   input  tracker_load_type              tracker_load,
   output logic                          rsp_point_valid,
   output logic signed [COORD_W-1:0]     rsp_point_x,
   output logic signed [COORD_W-1:0]     rsp_point_y,
   output logic signed [Z_W-1:0]         rsp_point_z,
   output logic                          rsp_frame_end,
   output logic [DEPTH_W-1:0]            rsp_min_depth_seen,
   output logic [DEPTH_W-1:0]            rsp_max_depth_seen
);

   localparam int CNT_W = $clog2(MAX_IMAGE_DIM);
   localparam int DIM_W = CNT_W + 1;
   localparam int MAG_W = CNT_W + 1;
   localparam int SGN_W = MAG_W + 1;
   localparam int P1_W  = MAG_W + DEPTH_W;
   localparam int P2_W  = P1_W + RECIP_W;
   localparam int Q_W   = P2_W + 1 - COORD_SHIFT;
   localparam int QX_W  = (Q_W > COORD_W + 1) ? Q_W : COORD_W + 1;
   localparam logic [QX_W-1:0] LIM_NEG = QX_W'(1) << (COORD_W - 1);
   localparam logic [QX_W-1:0] LIM_POS = LIM_NEG - QX_W'(1);
   localparam logic [P2_W:0]   ROUND_UP = (P2_W + 1)'((1 << COORD_SHIFT) - 1);

   // floor of signed product over 2^21, saturated to the coordinate range
   function automatic logic [COORD_W-1:0] project(input logic neg,
                                                   input logic [P2_W-1:0] prod);
      logic [P2_W:0]   sum;
      logic [QX_W-1:0] q;
      sum = neg ? ((P2_W + 1)'(prod) + ROUND_UP) : (P2_W + 1)'(prod);
      q   = QX_W'(sum[P2_W:COORD_SHIFT]);
      if (neg) begin
         if (q > LIM_NEG) begin
            project = COORD_W'(LIM_NEG);
         end else begin
            project = COORD_W'(QX_W'(0) - q);
         end
      end else begin
         if (q > LIM_POS) begin
            project = COORD_W'(LIM_POS);
         end else begin
            project = COORD_W'(q);
         end
      end
   endfunction

   logic [CNT_W-1:0]   col_ff, col_in;
   logic [CNT_W-1:0]   row_ff, row_in;
   logic [DEPTH_W-1:0] min_ff, min_in;
   logic [DEPTH_W-1:0] max_ff, max_in;

   logic [DEPTH_W-1:0] depth_ff;
   logic               valid_ff;
   logic               frame_end_ff;
   logic               x_neg_ff, y_neg_ff;
   logic [MAG_W-1:0]   x_mag_ff, y_mag_ff;
   logic [P1_W-1:0]    x_part_ff, y_part_ff;
   logic [P2_W-1:0]    x_prod_ff, y_prod_ff;

   logic                      out_valid_ff;
   logic signed [COORD_W-1:0] out_x_ff, out_y_ff;
   logic signed [Z_W-1:0]     out_z_ff;
   logic                      out_frame_end_ff;
   logic [DEPTH_W-1:0]        out_min_ff, out_max_ff;

   logic               row_end, last_row, depth_ok;
   logic [SGN_W-1:0]   ox, oy, ox_abs, oy_abs;

   // pixel position and centred offsets
   always_comb begin
      depth_ok = req_depth_sample != INVALID_DEPTH;
      row_end  = DIM_W'(col_ff) >= (image_width - DIM_W'(1));
      last_row = DIM_W'(row_ff) >= (image_height - DIM_W'(1));
      ox       = {1'b0, col_ff, 1'b0} - {1'b0, image_width};
      oy       = {1'b0, image_height} - {1'b0, row_ff, 1'b0};
      ox_abs   = ox[SGN_W-1] ? (SGN_W'(0) - ox) : ox;
      oy_abs   = oy[SGN_W-1] ? (SGN_W'(0) - oy) : oy;
   end

   // counters and trackers
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      min_in = min_ff;
      max_in = max_ff;
      if (cmd.take) begin
         if (row_end) begin
            col_in = '0;
            row_in = last_row ? '0 : row_ff + CNT_W'(1);
         end else begin
            col_in = col_ff + CNT_W'(1);
         end
      end
      if (tracker_load.load_min) begin
         min_in = tracker_load.value;
      end else if (cmd.take && depth_ok && (req_depth_sample < min_ff)) begin
         min_in = req_depth_sample;
      end
      if (tracker_load.load_max) begin
         max_in = tracker_load.value;
      end else if (cmd.take && depth_ok && (req_depth_sample > max_ff)) begin
         max_in = req_depth_sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         min_ff <= RESET_MIN_DEPTH;
         max_ff <= RESET_MAX_DEPTH;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
         min_ff <= min_in;
         max_ff <= max_in;
      end
   end

   // request capture and the two multiply steps
   always_ff @(posedge clock) begin
      if (cmd.take) begin
         depth_ff     <= req_depth_sample;
         valid_ff     <= depth_ok;
         frame_end_ff <= row_end && last_row;
         x_neg_ff     <= ox[SGN_W-1];
         y_neg_ff     <= oy[SGN_W-1];
         x_mag_ff     <= ox_abs[MAG_W-1:0];
         y_mag_ff     <= oy_abs[MAG_W-1:0];
      end
      if (cmd.mul1) begin
         x_part_ff <= P1_W'(x_mag_ff) * P1_W'(depth_ff);
         y_part_ff <= P1_W'(y_mag_ff) * P1_W'(depth_ff);
      end
      if (cmd.mul2) begin
         x_prod_ff <= P2_W'(x_part_ff) * P2_W'(recip_focal_x);
         y_prod_ff <= P2_W'(y_part_ff) * P2_W'(recip_focal_y);
      end
   end

   // output register, rounding and saturation on the way in
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_valid_ff     <= valid_ff;
         out_x_ff         <= valid_ff ? project(x_neg_ff, x_prod_ff) : '0;
         out_y_ff         <= valid_ff ? project(y_neg_ff, y_prod_ff) : '0;
         out_z_ff         <= valid_ff ? (Z_W'(0) - Z_W'(depth_ff)) : '0;
         out_frame_end_ff <= frame_end_ff;
         out_min_ff       <= min_ff;
         out_max_ff       <= max_ff;
      end
   end

   assign rsp_point_valid    = out_valid_ff;
   assign rsp_point_x        = out_x_ff;
   assign rsp_point_y        = out_y_ff;
   assign rsp_point_z        = out_z_ff;
   assign rsp_frame_end      = out_frame_end_ff;
   assign rsp_min_depth_seen = out_min_ff;
   assign rsp_max_depth_seen = out_max_ff;

endmodule

>>> rtl/depth_to_point_cloud_unit.sv
// depth image to point cloud back-projection
// requests carry one 16-bit depth pixel in raster order on req_valid /
// req_stall; responses carry one point per pixel on rsp_valid / rsp_stall,
// with a validity flag, x, y, z, the frame end flag and the running depth
// minimum and maximum including that pixel.
// each request runs through a four-state controller: capture, two
// multiply steps (offset times depth, then times reciprocal focal length)
// and a load into the output register, which raises rsp_valid. a new
// request is taken only once the controller is back in idle, after the
// previous one has been loaded into the output register.
// a stalled response holds in the output register; the next request is
// still taken and worked on, and waits in its last step until the output
// register is free.
// configuration is a plain write port (csr_write_enable, csr_index,
// csr_write_data); writes to the min or max start values also reload the
// running trackers. synchronous reset clears the pixel counters, loads
// the register defaults and empties the output register.
module depth_to_point_cloud_unit
   import dpc_pkg::*;
#(
   parameter int MAX_IMAGE_DIM = 4096
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [DEPTH_W-1:0]        req_depth_sample,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic                      rsp_point_valid,
   output logic signed [COORD_W-1:0] rsp_point_x,
   output logic signed [COORD_W-1:0] rsp_point_y,
   output logic signed [Z_W-1:0]     rsp_point_z,
   output logic                      rsp_frame_end,
   output logic [DEPTH_W-1:0]        rsp_min_depth_seen,
   output logic [DEPTH_W-1:0]        rsp_max_depth_seen,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]     csr_write_data
);

   localparam int DIM_W = $clog2(MAX_IMAGE_DIM) + 1;

   dp_cmd_type         cmd;
   tracker_load_type   tracker_load;
   logic [DIM_W-1:0]   image_width, image_height;
   logic [RECIP_W-1:0] recip_focal_x, recip_focal_y;

   // configuration registers
   dpc_csr #(
      .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
   ) u_csr (
      .clock           (clock),
      .reset           (reset),
      .csr_write_enable(csr_write_enable),
      .csr_index       (csr_index),
      .csr_write_data  (csr_write_data),
      .image_width     (image_width),
      .image_height    (image_height),
      .recip_focal_x   (recip_focal_x),
      .recip_focal_y   (recip_focal_y),
      .tracker_load    (tracker_load)
   );

   // sequencer and handshakes
   dpc_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .cmd      (cmd)
   );

   // counters, trackers, multiplies and output register
   dpc_datapath #(
      .MAX_IMAGE_DIM(MAX_IMAGE_DIM)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_depth_sample  (req_depth_sample),
      .image_width       (image_width),
      .image_height      (image_height),
      .recip_focal_x     (recip_focal_x),
      .recip_focal_y     (recip_focal_y),
      .tracker_load      (tracker_load),
      .rsp_point_valid   (rsp_point_valid),
      .rsp_point_x       (rsp_point_x),
      .rsp_point_y       (rsp_point_y),
      .rsp_point_z       (rsp_point_z),
      .rsp_frame_end     (rsp_frame_end),
      .rsp_min_depth_seen(rsp_min_depth_seen),
      .rsp_max_depth_seen(rsp_max_depth_seen)
   );

endmodule

>>> tb/sv/depth_to_point_cloud_unit_test.sv
`timescale 1ns / 100ps

module depth_to_point_cloud_unit_test;
   import dpc_pkg::*;

   localparam int IDLE_LIMIT    = 2000;
   localparam int SETTLE_CYCLES = 8;
   localparam int DIM_LIMIT     = 4096;
   localparam logic [CSR_DATA_W-1:0] RECIP_FULL = {CSR_DATA_W{1'b1}};
   localparam logic [CSR_DATA_W-1:0] RECIP_Q24  = 25'h1000000;
   localparam logic [DEPTH_W-1:0]    DEEPEST    = 16'hFFFE;

   typedef struct packed {
      logic                      valid;
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic signed [Z_W-1:0]     z;
      logic                      frame_end;
      logic [DEPTH_W-1:0]        min_seen;
      logic [DEPTH_W-1:0]        max_seen;
   } point_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [DEPTH_W-1:0]        req_depth_sample = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_point_valid;
   logic signed [COORD_W-1:0] rsp_point_x;
   logic signed [COORD_W-1:0] rsp_point_y;
   logic signed [Z_W-1:0]     rsp_point_z;
   logic                      rsp_frame_end;
   logic [DEPTH_W-1:0]        rsp_min_depth_seen;
   logic [DEPTH_W-1:0]        rsp_max_depth_seen;
   logic                      csr_write_enable = 1'b0;
   csr_index_type             csr_index = CSR_IMAGE_WIDTH;
   logic [CSR_DATA_W-1:0]     csr_write_data = '0;

   // camera setup and pixel position as the block should hold them
   logic [DIM_REG_W-1:0] width_reg   = RESET_IMAGE_WIDTH;
   logic [DIM_REG_W-1:0] height_reg  = RESET_IMAGE_HEIGHT;
   logic [RECIP_W-1:0]   recip_x_reg = RESET_RECIP_FOCAL;
   logic [RECIP_W-1:0]   recip_y_reg = RESET_RECIP_FOCAL;
   logic [DEPTH_W-1:0]   nearest     = RESET_MIN_DEPTH;
   logic [DEPTH_W-1:0]   farthest    = RESET_MAX_DEPTH;
   int                   col_count   = 0;
   int                   row_count   = 0;

   logic [DEPTH_W-1:0] pending_depths[$];
   point_type          expected_points[$];
   int                 requests_issued   = 0;
   int                 responses_checked = 0;
   int                 error_count       = 0;
   int                 quiet_cycles      = 0;
   int                 send_idle_pct     = 0;
   int                 recv_idle_pct     = 0;

   depth_to_point_cloud_unit i_dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_depth_sample   (req_depth_sample),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_point_valid    (rsp_point_valid),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_point_z        (rsp_point_z),
      .rsp_frame_end      (rsp_frame_end),
      .rsp_min_depth_seen (rsp_min_depth_seen),
      .rsp_max_depth_seen (rsp_max_depth_seen),
      .csr_write_enable   (csr_write_enable),
      .csr_index          (csr_index),
      .csr_write_data     (csr_write_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic int clamp_dim(logic [DIM_REG_W-1:0] value);
      if (value == 0) return 1;
      if (value > DIM_LIMIT) return DIM_LIMIT;
      return int'(value);
   endfunction

   // floor of offset * depth * recip / 2^21, saturated to the coordinate range
   function automatic logic signed [COORD_W-1:0] backproject(longint offset,
         logic [DEPTH_W-1:0] depth, logic [RECIP_W-1:0] recip);
      longint scaled;
      scaled = (offset * longint'(depth) * longint'(recip)) >>> COORD_SHIFT;
      if (scaled > 64'sd4294967295) return {1'b0, {(COORD_W-1){1'b1}}};
      if (scaled < -64'sd4294967296) return {1'b1, {(COORD_W-1){1'b0}}};
      return scaled[COORD_W-1:0];
   endfunction

   // point for one pixel; advances the raster position and depth range
   function automatic point_type project_pixel(logic [DEPTH_W-1:0] depth);
      point_type pt;
      int        w;
      int        h;
      logic      row_end;
      logic      last_row;
      w = clamp_dim(width_reg);
      h = clamp_dim(height_reg);
      row_end = col_count >= w - 1;
      last_row = row_count >= h - 1;
      pt = '0;
      pt.frame_end = row_end && last_row;
      if (depth != INVALID_DEPTH) begin
         pt.valid = 1'b1;
         pt.x = backproject(longint'(2 * col_count - w), depth, recip_x_reg);
         pt.y = backproject(longint'(h - 2 * row_count), depth, recip_y_reg);
         pt.z = -{1'b0, depth};
         if (depth < nearest) nearest = depth;
         if (depth > farthest) farthest = depth;
      end
      pt.min_seen = nearest;
      pt.max_seen = farthest;
      if (row_end) begin
         col_count = 0;
         row_count = last_row ? 0 : row_count + 1;
      end else begin
         col_count = col_count + 1;
      end
      return pt;
   endfunction

   task automatic check_field(string field, logic signed [63:0] want,
         logic signed [63:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_points = {expected_points, project_pixel(req_depth_sample)};
         if (!req_valid || !req_stall) begin
            if (pending_depths.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_depth_sample <= pending_depths.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      point_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_points.size() == 0) begin
               error_count++;
               $display("%0t: response with no request pending, expected none, actual x %0d",
                  $time, rsp_point_x);
            end else begin
               want = expected_points.pop_front();
               responses_checked++;
               check_field("point_valid", want.valid, rsp_point_valid);
               check_field("point_x", want.x, rsp_point_x);
               check_field("point_y", want.y, rsp_point_y);
               check_field("point_z", want.z, rsp_point_z);
               check_field("frame_end", want.frame_end, rsp_frame_end);
               check_field("min_depth_seen", want.min_seen, rsp_min_depth_seen);
               check_field("max_depth_seen", want.max_seen, rsp_max_depth_seen);
            end
         end
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset) begin
         quiet_cycles = 0;
      end else if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= IDLE_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   task automatic send_depth(logic [DEPTH_W-1:0] depth);
      pending_depths = {pending_depths, depth};
      requests_issued++;
   endtask

   // all requests answered, then let the pipeline settle
   task automatic wait_for_drain();
      while (responses_checked != requests_issued) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(csr_index_type idx, logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      case (idx)
         CSR_IMAGE_WIDTH:       width_reg = value[DIM_REG_W-1:0];
         CSR_IMAGE_HEIGHT:      height_reg = value[DIM_REG_W-1:0];
         CSR_RECIP_FOCAL_X:     recip_x_reg = value[RECIP_W-1:0];
         CSR_RECIP_FOCAL_Y:     recip_y_reg = value[RECIP_W-1:0];
         CSR_INITIAL_MIN_DEPTH: nearest = value[DEPTH_W-1:0];
         CSR_INITIAL_MAX_DEPTH: farthest = value[DEPTH_W-1:0];
         default: ;
      endcase
      csr_write_enable <= 1'b0;
   endtask

   function automatic logic [DEPTH_W-1:0] pick_depth();
      int r;
      r = $urandom_range(99);
      if (r < 10) return INVALID_DEPTH;
      if (r < 15) return '0;
      if (r < 20) return DEEPEST;
      if (r < 25) return DEPTH_W'($urandom_range(1, 16));
      return DEPTH_W'($urandom_range(16'hFFFF));
   endfunction

   // mostly small frames so rows and frames wrap often
   function automatic logic [CSR_DATA_W-1:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 80) return CSR_DATA_W'($urandom_range(1, 8));
      if (r < 86) return '0;
      if (r < 94) return CSR_DATA_W'($urandom_range(4096, 8191));
      return CSR_DATA_W'($urandom_range(9, 64));
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_recip();
      int r;
      r = $urandom_range(99);
      if (r < 15) return CSR_DATA_W'(256);
      if (r < 25) return RECIP_Q24;
      if (r < 35) return RECIP_FULL;
      if (r < 40) return CSR_DATA_W'($urandom_range(255));
      return CSR_DATA_W'($urandom_range(256, 25'h1FFFFFF));
   endfunction

   task automatic run_random_phase();
      int count;
      count = $urandom_range(30, 60);
      write_register(CSR_IMAGE_WIDTH, pick_dim());
      write_register(CSR_IMAGE_HEIGHT, pick_dim());
      if ($urandom_range(1)) write_register(CSR_RECIP_FOCAL_X, pick_recip());
      if ($urandom_range(1)) write_register(CSR_RECIP_FOCAL_Y, pick_recip());
      if ($urandom_range(3) == 0)
         write_register(CSR_INITIAL_MIN_DEPTH, CSR_DATA_W'($urandom_range(16'hFFFF)));
      if ($urandom_range(3) == 0)
         write_register(CSR_INITIAL_MAX_DEPTH, CSR_DATA_W'($urandom_range(16'hFFFF)));
      repeat (count) send_depth(pick_depth());
      wait_for_drain();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // depth extremes at the reset geometry and tracker values
      send_idle_pct = 33;
      recv_idle_pct = 75;
      send_depth('0);
      send_depth(DEEPEST);
      send_depth(INVALID_DEPTH);
      send_depth(16'd1);
      send_depth(16'h5555);
      send_depth(16'hAAAA);
      send_depth(INVALID_DEPTH);
      send_depth(16'h8000);
      wait_for_drain();

      // tiny frame entered mid-row, zero-depth pixel at frame end
      write_register(CSR_IMAGE_WIDTH, 25'd3);
      write_register(CSR_IMAGE_HEIGHT, 25'd2);
      write_register(CSR_RECIP_FOCAL_X, RECIP_FULL);
      write_register(CSR_RECIP_FOCAL_Y, 25'd256);
      write_register(CSR_INITIAL_MIN_DEPTH, 25'h8000);
      write_register(CSR_INITIAL_MAX_DEPTH, 25'h7FFF);
      send_depth(16'd100);
      send_depth(INVALID_DEPTH);
      send_depth(DEEPEST);
      send_depth('0);
      send_depth(16'd40000);
      send_depth(INVALID_DEPTH);
      send_depth(16'd7);
      wait_for_drain();

      // zero sizes act as one pixel, trackers preloaded at their extremes
      write_register(CSR_IMAGE_WIDTH, '0);
      write_register(CSR_IMAGE_HEIGHT, '0);
      write_register(CSR_INITIAL_MIN_DEPTH, '0);
      write_register(CSR_INITIAL_MAX_DEPTH, 25'hFFFF);
      send_depth(DEEPEST);
      send_depth(INVALID_DEPTH);
      send_depth('0);
      wait_for_drain();

      // oversized frame, full reciprocals: largest offsets at the corner
      write_register(CSR_IMAGE_WIDTH, 25'd8191);
      write_register(CSR_IMAGE_HEIGHT, 25'd4097);
      write_register(CSR_RECIP_FOCAL_Y, RECIP_FULL);
      send_depth(DEEPEST);
      send_depth(DEEPEST);
      send_depth(INVALID_DEPTH);
      wait_for_drain();

      repeat (8) run_random_phase();

      send_idle_pct = 75;
      recv_idle_pct = 33;
      repeat (8) run_random_phase();

      send_idle_pct = 0;
      recv_idle_pct = 0;
      repeat (4) run_random_phase();

      if (error_count == 0 && expected_points.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
